// File: rtl/bf3_pkg.sv
// Shared types, constants and a helper function of the 3x3 box filter.
package bf3_pkg;

  localparam int MAX_DIM_DEF = 1024;
  localparam int FS_W        = 11;
  localparam int CH_W        = 16;
  localparam int PIX_W       = 3 * CH_W;
  localparam int SUM_W       = 20;
  localparam int RCP_W       = 23;
  localparam int DIV_SHIFT   = 23;
  localparam int FIFO_DEPTH  = 4;
  localparam int PTR_W       = $clog2(FIFO_DEPTH);
  localparam int CNT_W       = $clog2(FIFO_DEPTH + 1);

  localparam logic [FS_W-1:0] FS_RESET = FS_W'(1024);

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    DIV2,
    DIV4,
    DIV6,
    DIV9
  } div_e;

  typedef struct packed {
    logic            cmd;
    logic [CH_W-1:0] in_red;
    logic [CH_W-1:0] in_green;
    logic [CH_W-1:0] in_blue;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] out_red;
    logic [CH_W-1:0] out_green;
    logic [CH_W-1:0] out_blue;
    logic            frame_done;
  } out_item_t;

  // Neighborhood sums of one result before the division.
  typedef struct packed {
    logic [SUM_W-1:0] sum_r;
    logic [SUM_W-1:0] sum_g;
    logic [SUM_W-1:0] sum_b;
    div_e             div;
    logic             done;
  } res_t;

  // Position flags of the item held in the working register.
  typedef struct packed {
    logic is_pixel;
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic c_last;
    logic fw_load;
    logic k_zero;
    logic k_last;
  } s1_ctl_t;

  // Reciprocals scaled by 2^DIV_SHIFT, rounded up; exact for sums below 2^20.
  function automatic logic [RCP_W-1:0] recip(input div_e d);
    logic [RCP_W-1:0] m;
    unique case (d)
      DIV2:    m = RCP_W'(4194304);
      DIV4:    m = RCP_W'(2097152);
      DIV6:    m = RCP_W'(1398102);
      DIV9:    m = RCP_W'(932068);
      default: m = RCP_W'(2097152);
    endcase
    return m;
  endfunction

endpackage

// File: rtl/bf3_if.sv
// Valid/ready channel interfaces for pixel items and filtered results.
interface bf3_in_if;
  import bf3_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface bf3_out_if;
  import bf3_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/box_filter_3x3_rgb.sv
// Top level of the streaming 3x3 box filter for square RGB frames.
//
// Pixels enter on in_ch_i in raster order, cmd at pixel. Each pixel at row r
// and column c (both at least 1) yields the mean of the clipped 3x3 area
// around pixel (r-1,c-1); the last column of a row yields one extra result.
// After the last pixel of a frame, one flush item (cmd at flush) per column
// brings out the final row; its last result carries frame_done. Pixels sent
// during the flush and flushes sent outside it are taken and dropped.
// The frame size is written through cfg_we_i/cfg_wdata_i; the user must write
// it only while the block is idle, which the block itself does not enforce.
// A write restarts the frame position. From an input transfer to its first
// result on out_ch_o, an item passes the working register, loaded with the
// line-store read, then the result queue, then the output register where the
// division lands. Throughput is one item per cycle while the result queue has
// room. The line stores are one RAM with one read and one write per cycle; a
// row end yields one extra result. Reset clears the position counters and the
// queue; the line stores are not cleared. When out_ch_o stalls, the 4-entry
// result queue fills and then in_ch_i.ready drops until there is room again.
module box_filter_3x3_rgb #(
  parameter int MAX_DIM = bf3_pkg::MAX_DIM_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [bf3_pkg::FS_W-1:0] cfg_wdata_i,
  bf3_in_if.sink                   in_ch_i,
  bf3_out_if.source                out_ch_o
);
  import bf3_pkg::*;

  localparam int AW    = $clog2(MAX_DIM);
  localparam int DW    = $clog2(MAX_DIM + 1);
  localparam int CMP_W = (DW > FS_W) ? DW : FS_W;
  localparam int RAM_W = 2 * PIX_W;

  logic [FS_W-1:0] fs_q, fs_d;
  logic [AW-1:0]   row_q, row_d, col_q, col_d, fl_q, fl_d;
  logic            flushing_q, flushing_d;

  logic             s1_v_q, s1_v_d;
  s1_ctl_t          s1_ctl_q, ctl_d;
  logic [PIX_W-1:0] s1_px_q;
  logic [AW-1:0]    s1_col_q;

  logic             byp_q;
  logic [RAM_W-1:0] byp_data_q;

  logic [CMP_W-1:0] fs_ext;
  logic [DW-1:0]    dim;
  logic             accept, is_flush, pix_take, flush_take, s1_load, s1_go;
  logic             c_last, r_last, k_last;
  logic [AW-1:0]    rd_addr;
  logic             ram_we;
  logic [RAM_W-1:0] ram_rdata, rd_data, wdata;
  res_t             res0, res1;
  logic [1:0]       n_res;
  logic [CNT_W-1:0] room;

  // Frame size saturated to the supported range.
  assign fs_ext = CMP_W'(fs_q);
  always_comb begin
    if (fs_q < FS_W'(2)) begin
      dim = DW'(2);
    end else if (fs_ext > CMP_W'(MAX_DIM)) begin
      dim = DW'(MAX_DIM);
    end else begin
      dim = DW'(fs_ext);
    end
  end

  assign c_last = (DW'(col_q) + DW'(1)) == dim;
  assign r_last = (DW'(row_q) + DW'(1)) == dim;
  assign k_last = (DW'(fl_q) + DW'(1)) == dim;

  assign is_flush   = in_ch_i.data.cmd == CMD_FLUSH;
  assign accept     = in_ch_i.valid && in_ch_i.ready;
  assign pix_take   = accept && !is_flush && !flushing_q;
  assign flush_take = accept && is_flush && flushing_q;
  assign s1_load    = pix_take || flush_take;

  assign s1_go         = s1_v_q && (CNT_W'(n_res) <= room);
  assign in_ch_i.ready = !s1_v_q || s1_go;

  always_comb begin
    ctl_d.is_pixel = !is_flush;
    ctl_d.r_ge1    = row_q != '0;
    ctl_d.r_ge2    = row_q > AW'(1);
    ctl_d.c_ge1    = col_q != '0;
    ctl_d.c_ge2    = col_q > AW'(1);
    ctl_d.c_last   = c_last;
    ctl_d.fw_load  = r_last && (col_q == '0);
    ctl_d.k_zero   = fl_q == '0;
    ctl_d.k_last   = k_last;

    if (is_flush) begin
      rd_addr = k_last ? '0 : fl_q + AW'(1);
    end else begin
      rd_addr = col_q;
    end
  end

  always_comb begin
    fs_d       = fs_q;
    row_d      = row_q;
    col_d      = col_q;
    fl_d       = fl_q;
    flushing_d = flushing_q;
    if (cfg_we_i) begin
      fs_d       = cfg_wdata_i;
      row_d      = '0;
      col_d      = '0;
      fl_d       = '0;
      flushing_d = 1'b0;
    end else if (pix_take) begin
      if (c_last) begin
        col_d = '0;
        if (r_last) begin
          row_d      = '0;
          fl_d       = '0;
          flushing_d = 1'b1;
        end else begin
          row_d = row_q + AW'(1);
        end
      end else begin
        col_d = col_q + AW'(1);
      end
    end else if (flush_take) begin
      if (k_last) begin
        row_d      = '0;
        col_d      = '0;
        fl_d       = '0;
        flushing_d = 1'b0;
      end else begin
        fl_d = fl_q + AW'(1);
      end
    end
    s1_v_d = s1_load ? 1'b1 : (s1_go ? 1'b0 : s1_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q       <= FS_RESET;
      row_q      <= '0;
      col_q      <= '0;
      fl_q       <= '0;
      flushing_q <= 1'b0;
      s1_v_q     <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      fs_q       <= fs_d;
      row_q      <= row_d;
      col_q      <= col_d;
      fl_q       <= fl_d;
      flushing_q <= flushing_d;
      s1_v_q     <= s1_v_d;
      // A read of the column being written in the same cycle takes the new data.
      if (s1_load) begin
        byp_q <= ram_we && (rd_addr == s1_col_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_load) begin
      s1_ctl_q   <= ctl_d;
      s1_px_q    <= {in_ch_i.data.in_red, in_ch_i.data.in_green, in_ch_i.data.in_blue};
      s1_col_q   <= col_q;
      byp_data_q <= wdata;
    end
  end

  assign ram_we  = s1_go && s1_ctl_q.is_pixel;
  assign rd_data = byp_q ? byp_data_q : ram_rdata;

  bf3_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_DIM)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_col_q),
    .wdata_i (wdata),
    .re_i    (s1_load),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  bf3_window u_window (
    .clk_i   (clk_i),
    .fire_i  (s1_go),
    .ctl_i   (s1_ctl_q),
    .px_i    (s1_px_q),
    .rd_i    (rd_data),
    .wdata_o (wdata),
    .res0_o  (res0),
    .res1_o  (res1),
    .n_o     (n_res)
  );

  bf3_out u_out (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (s1_go ? n_res : 2'd0),
    .res0_i   (res0),
    .res1_i   (res1),
    .room_o   (room),
    .out_ch   (out_ch_o)
  );

endmodule

// File: rtl/bf3_ram.sv
// Generic simple dual-port RAM with registered read data.
module bf3_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/bf3_window.sv
// 3x3 pixel window, last-row flush window and neighborhood sums.
module bf3_window (
  input  logic                         clk_i,
  input  logic                         fire_i,
  input  bf3_pkg::s1_ctl_t             ctl_i,
  input  logic [bf3_pkg::PIX_W-1:0]    px_i,
  input  logic [2*bf3_pkg::PIX_W-1:0]  rd_i,
  output logic [2*bf3_pkg::PIX_W-1:0]  wdata_o,
  output bf3_pkg::res_t                res0_o,
  output bf3_pkg::res_t                res1_o,
  output logic [1:0]                   n_o
);
  import bf3_pkg::*;

  // Pixel window, indexed [column][row]; column 2 is the newest.
  logic [PIX_W-1:0]   wc_q [3][3];
  logic [PIX_W-1:0]   wc_d [3][3];
  // Flush window: each column holds {upper row, lower row} of the final pair.
  logic [2*PIX_W-1:0] fw_q [3];
  logic [2*PIX_W-1:0] fw_d [3];

  logic [SUM_W-1:0] pcs [3][3];
  logic [SUM_W-1:0] fcs [3][3];
  logic [SUM_W-1:0] psum1 [3];
  logic [SUM_W-1:0] psum2 [3];
  logic [SUM_W-1:0] fsum [3];
  div_e             pdiv1, pdiv2, fdiv;

  function automatic logic [SUM_W-1:0] chan(input logic [PIX_W-1:0] p, input int unsigned ch);
    return SUM_W'(p[(2 - ch) * CH_W +: CH_W]);
  endfunction

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      wc_d[0][j] = wc_q[1][j];
      wc_d[1][j] = wc_q[2][j];
    end
    wc_d[2][0] = rd_i[2*PIX_W-1:PIX_W];
    wc_d[2][1] = rd_i[PIX_W-1:0];
    wc_d[2][2] = px_i;

    fw_d[0] = fw_q[1];
    fw_d[1] = fw_q[2];
    fw_d[2] = rd_i;
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      for (int ch = 0; ch < 3; ch++) begin
        pcs[j][ch] = (ctl_i.r_ge2 ? chan(wc_d[j][0], ch) : '0)
                     + chan(wc_d[j][1], ch) + chan(wc_d[j][2], ch);
        fcs[j][ch] = chan(fw_d[j][2*PIX_W-1:PIX_W], ch) + chan(fw_d[j][PIX_W-1:0], ch);
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      psum1[ch] = (ctl_i.c_ge2 ? pcs[0][ch] : '0) + pcs[1][ch] + pcs[2][ch];
      psum2[ch] = pcs[1][ch] + pcs[2][ch];
      fsum[ch]  = (ctl_i.k_zero ? '0 : fcs[0][ch]) + fcs[1][ch]
                  + (ctl_i.k_last ? '0 : fcs[2][ch]);
    end
  end

  always_comb begin
    if (ctl_i.r_ge2 && ctl_i.c_ge2) begin
      pdiv1 = DIV9;
    end else if (ctl_i.r_ge2 || ctl_i.c_ge2) begin
      pdiv1 = DIV6;
    end else begin
      pdiv1 = DIV4;
    end
    pdiv2 = ctl_i.r_ge2 ? DIV6 : DIV4;
    if (ctl_i.k_zero && ctl_i.k_last) begin
      fdiv = DIV2;
    end else if (ctl_i.k_zero || ctl_i.k_last) begin
      fdiv = DIV4;
    end else begin
      fdiv = DIV6;
    end
  end

  always_comb begin
    res0_o.sum_r = ctl_i.is_pixel ? psum1[0] : fsum[0];
    res0_o.sum_g = ctl_i.is_pixel ? psum1[1] : fsum[1];
    res0_o.sum_b = ctl_i.is_pixel ? psum1[2] : fsum[2];
    res0_o.div   = ctl_i.is_pixel ? pdiv1 : fdiv;
    res0_o.done  = !ctl_i.is_pixel && ctl_i.k_last;

    res1_o.sum_r = psum2[0];
    res1_o.sum_g = psum2[1];
    res1_o.sum_b = psum2[2];
    res1_o.div   = pdiv2;
    res1_o.done  = 1'b0;

    if (!ctl_i.is_pixel) begin
      n_o = 2'd1;
    end else if (ctl_i.r_ge1 && ctl_i.c_ge1) begin
      n_o = ctl_i.c_last ? 2'd2 : 2'd1;
    end else begin
      n_o = 2'd0;
    end
  end

  // The line stores shift down: upper takes the old middle, middle takes the new pixel.
  assign wdata_o = {rd_i[PIX_W-1:0], px_i};

  always_ff @(posedge clk_i) begin
    if (fire_i && ctl_i.is_pixel) begin
      wc_q <= wc_d;
      if (ctl_i.fw_load) begin
        fw_q[2] <= {rd_i[PIX_W-1:0], px_i};
      end
    end else if (fire_i) begin
      fw_q <= fw_d;
    end
  end

endmodule

// File: rtl/bf3_out.sv
// Result queue, division by the neighborhood size and output register.
module bf3_out (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [1:0]                 push_n_i,
  input  bf3_pkg::res_t              res0_i,
  input  bf3_pkg::res_t              res1_i,
  output logic [bf3_pkg::CNT_W-1:0]  room_o,
  bf3_out_if.source                  out_ch
);
  import bf3_pkg::*;

  localparam int PROD_W = SUM_W + RCP_W;

  res_t             fifo_q [FIFO_DEPTH];
  logic [PTR_W-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_v_q, out_v_d;
  out_item_t        out_data_q;
  out_item_t        out_data_d;

  res_t              head;
  logic [RCP_W-1:0]  m;
  logic [PROD_W-1:0] prod_r, prod_g, prod_b;
  logic              pop;

  assign pop  = (cnt_q != '0) && (!out_v_q || out_ch.ready);
  assign head = fifo_q[rp_q];
  assign m    = recip(head.div);

  always_comb begin
    prod_r = PROD_W'(head.sum_r) * PROD_W'(m);
    prod_g = PROD_W'(head.sum_g) * PROD_W'(m);
    prod_b = PROD_W'(head.sum_b) * PROD_W'(m);

    out_data_d.out_red    = prod_r[DIV_SHIFT +: CH_W];
    out_data_d.out_green  = prod_g[DIV_SHIFT +: CH_W];
    out_data_d.out_blue   = prod_b[DIV_SHIFT +: CH_W];
    out_data_d.frame_done = head.done;

    wp_d    = wp_q + PTR_W'(push_n_i);
    rp_d    = pop ? rp_q + PTR_W'(1) : rp_q;
    cnt_d   = cnt_q + CNT_W'(push_n_i) - CNT_W'(pop);
    out_v_d = pop ? 1'b1 : (out_ch.ready ? 1'b0 : out_v_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q    <= '0;
      rp_q    <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      wp_q    <= wp_d;
      rp_q    <= rp_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      fifo_q[wp_q] <= res0_i;
    end
    if (push_n_i == 2'd2) begin
      fifo_q[wp_q + PTR_W'(1)] <= res1_i;
    end
    if (pop) begin
      out_data_q <= out_data_d;
    end
  end

  assign room_o       = CNT_W'(FIFO_DEPTH) - cnt_q;
  assign out_ch.valid = out_v_q;
  assign out_ch.data  = out_data_q;

endmodule

// File: rtl/bf3_checker.sv
// Port-level checks of the box filter, bound to its top level.
module bf3_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_i,
  input logic               out_valid_i,
  input logic               out_ready_i,
  input bf3_pkg::out_item_t out_data_i
);
  import bf3_pkg::*;

  // The block only holds off input while it has results waiting downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed");

  // A frame always ends with several results, so two frame ends never sit back to back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && out_data_i.frame_done
    |=> !(out_valid_i && out_data_i.frame_done))
    else $error("frame end marked on consecutive results");

  // While reset holds, no input is left waiting behind an offered result.
  assert property (@(posedge clk_i)
    !rst_ni |-> !(in_valid_i && !in_ready_i && out_valid_i))
    else $error("state held through reset");

endmodule

bind box_filter_3x3_rgb bf3_checker u_bf3_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_ch_i.valid),
  .in_ready_i  (in_ch_i.ready),
  .out_valid_i (out_ch_o.valid),
  .out_ready_i (out_ch_o.ready),
  .out_data_i  (out_ch_o.data)
);
